FILE: sv/lgi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgi_pkg
// Shared types, codes and fixed-point helpers of the grid interpolator.
// ----------------------------------------------------------------------------
package lgi_pkg;

  // item kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // configuration register indexes
  localparam logic CFG_ORDER = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // interpolation orders
  localparam logic [2:0] ORD_LINEAR    = 3'd0;
  localparam logic [2:0] ORD_QUADRATIC = 3'd1;
  localparam logic [2:0] ORD_CUBIC     = 3'd2;
  localparam logic [2:0] ORD_QUARTIC   = 3'd3;
  localparam logic [2:0] ORD_ALL       = 3'd4;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FEW     = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int DVD_W = 48;  // |q - g| scaled by 2^16
  localparam int DSR_W = 32;  // |g_i - g_j|

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct packed {
    logic               is_query;
    logic [5:0]         index;
    logic signed [31:0] coord;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] coord;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } entry_t;

  // product / 2^16, truncated toward zero
  function automatic logic signed [47:0] trunc_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd65535 : 64'sd0);
    return t[63:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic [16:0] hi;
    hi = v[47:31];
    if (hi == 17'h0 || hi == 17'h1ffff) return v[31:0];
    return v[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

FILE: sv/lgi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgi_front
// Input stage: takes items, drops loads beyond the grid store, packs commands.
// ----------------------------------------------------------------------------
module lgi_front import lgi_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] abscissa,
  input  logic signed [31:0] sample_re,
  input  logic signed [31:0] sample_im,
  input  logic signed [31:0] query_point,
  output logic               push,
  input  logic               push_ready,
  output cmd_t               push_cmd
);

  logic fv;
  cmd_t fcmd;
  logic keep;

  assign keep     = (func == FUNC_QUERY) || ({26'b0, point_index} < MAX_POINTS);
  assign in_ready = !fv || push_ready;
  assign push     = fv;
  assign push_cmd = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      if (in_valid && in_ready) fv <= keep;
      else if (fv && push_ready) fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fcmd.is_query <= (func == FUNC_QUERY);
      fcmd.index    <= point_index;
      fcmd.coord    <= (func == FUNC_QUERY) ? query_point : abscissa;
      fcmd.re       <= sample_re;
      fcmd.im       <= sample_im;
    end
  end

endmodule

FILE: sv/lgi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgi_queue
// Short command queue between the input stage and the engine.
// ----------------------------------------------------------------------------
module lgi_queue import lgi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  cmd_t         slots [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != (QW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

FILE: sv/lgi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgi_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lgi_div import lgi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNTW = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DVD_W-1:0] quo;
  logic [CNTW-1:0]  cnt;
  logic [DSR_W:0]   sh;
  logic [DSR_W+1:0] diff;
  logic             ge;

  assign sh       = {rem, quo[DVD_W-1]};
  assign diff     = {1'b0, sh} - {2'b0, dsr};
  assign ge       = !diff[DSR_W+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DSR_W-1:0] : sh[DSR_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

FILE: sv/lgi_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgi_engine
// Grid store, interval search, stencil selection and Lagrange evaluation.
// ----------------------------------------------------------------------------
module lgi_engine import lgi_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  input  logic [2:0]         interp_order,
  input  logic [6:0]         point_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_re,
  output logic signed [31:0] result_im,
  output logic [1:0]         status
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int ACCW = 48 + $clog2(MAX_POINTS) + 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD0  = 5'd1;
  localparam logic [4:0] S_HIT0 = 5'd2;
  localparam logic [4:0] S_SCAN = 5'd3;
  localparam logic [4:0] S_CLS  = 5'd4;
  localparam logic [4:0] S_LI   = 5'd5;
  localparam logic [4:0] S_LI2  = 5'd6;
  localparam logic [4:0] S_LJ   = 5'd7;
  localparam logic [4:0] S_LD   = 5'd8;
  localparam logic [4:0] S_DIV  = 5'd9;
  localparam logic [4:0] S_MUL  = 5'd10;
  localparam logic [4:0] S_WUPD = 5'd11;
  localparam logic [4:0] S_TRE  = 5'd12;
  localparam logic [4:0] S_TIM  = 5'd13;
  localparam logic [4:0] S_TACC = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  logic [4:0] state;

  entry_t mem [MAX_POINTS];
  entry_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;

  logic signed [31:0] q;
  logic signed [31:0] prev;
  logic [CW-1:0] n_c, n_r, i, cl, li, j, start_r, stop_r;
  logic signed [31:0] gi, si_re, si_im, w, ratio;
  logic signed [63:0] prod;
  logic signed [31:0] mul_b;
  logic signed [ACCW-1:0] acc_re, acc_im;
  logic signed [31:0] res_re, res_im;
  logic [1:0]         res_st;
  logic               neg_r;

  // stencil selection
  logic [CW-1:0] c1, c2, cls_start, cls_stop;
  logic          cls_few;

  // ratio operands
  logic signed [32:0] den, num;
  logic [31:0]        den_mag, num_mag;
  logic               div_start, div_busy, div_done;
  logic [DVD_W-1:0]   div_q;
  logic signed [31:0] ratio_sat;

  logic signed [47:0] term;
  logic signed [ACCW-1:0] term_ext;

  assign n_c = ({25'b0, point_count} > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign mem_we  = cmd_pop && !cmd.is_query;
  assign wr_addr = AW'({26'b0, cmd.index});

  always_comb begin
    unique case (state)
      S_HIT0:  rd_addr = AW'(1);
      S_SCAN:  rd_addr = AW'(i + CW'(2));
      S_LI:    rd_addr = li[AW-1:0];
      S_LJ:    rd_addr = j[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= '{cmd.coord, cmd.re, cmd.im};
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    cls_few   = 1'b0;
    cls_start = '0;
    cls_stop  = '0;
    c1        = cl;
    c2        = cl;
    unique case (interp_order)
      ORD_LINEAR: begin
        cls_start = cl;
        cls_stop  = cl + CW'(2);
      end
      ORD_QUADRATIC: begin
        cls_few   = n_r < CW'(3);
        c1        = (cl == '0) ? CW'(1) : cl;
        cls_start = c1 - CW'(1);
        cls_stop  = c1 + CW'(2);
      end
      ORD_CUBIC: begin
        cls_few   = n_r < CW'(4);
        c1        = (cl == '0) ? CW'(1) : cl;
        c2        = (c1 == n_r - CW'(2)) ? n_r - CW'(3) : c1;
        cls_start = c2 - CW'(1);
        cls_stop  = c2 + CW'(3);
      end
      ORD_QUARTIC: begin
        cls_few   = n_r < CW'(5);
        c1        = (cl <= CW'(1)) ? CW'(2) : cl;
        c2        = (c1 == n_r - CW'(2)) ? n_r - CW'(3) : c1;
        cls_start = c2 - CW'(2);
        cls_stop  = c2 + CW'(3);
      end
      ORD_ALL: begin
        cls_start = '0;
        cls_stop  = n_r;
      end
      default: cls_few = 1'b1;
    endcase
  end

  assign den       = {gi[31], gi} - {rd_q.coord[31], rd_q.coord};
  assign num       = {q[31], q} - {rd_q.coord[31], rd_q.coord};
  assign den_mag   = den[32] ? 32'(-den) : den[31:0];
  assign num_mag   = num[32] ? 32'(-num) : num[31:0];
  assign div_start = (state == S_LD) && (den != '0);

  always_comb begin
    if (!neg_r) begin
      ratio_sat = (div_q > DVD_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : div_q[31:0];
    end else begin
      ratio_sat = (div_q > DVD_W'(32'h8000_0000)) ? 32'sh8000_0000 : -div_q[31:0];
    end
  end

  lgi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_mag, 16'b0}),
    .divisor  (den_mag),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (state)
      S_MUL:   mul_b = ratio;
      S_TRE:   mul_b = si_re;
      default: mul_b = si_im;
    endcase
  end

  assign term     = trunc_q16(prod);
  assign term_ext = {{(ACCW-48){term[47]}}, term};

  function automatic logic signed [31:0] sat_acc(input logic signed [ACCW-1:0] a);
    logic [ACCW-32:0] hi;
    hi = a[ACCW-1:31];
    if (hi == '0 || hi == '1) return a[31:0];
    return a[ACCW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  always_ff @(posedge clk) begin
    prod <= w * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result in the done step replaces the one leaving
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.is_query) begin
            q   <= cmd.coord;
            n_r <= n_c;
            if (n_c == '0) begin
              res_re <= '0;
              res_im <= '0;
              res_st <= ST_OUTSIDE;
              state  <= S_DONE;
            end else begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: state <= S_HIT0;
        S_HIT0: begin
          if (q == rd_q.coord) begin
            res_re <= rd_q.re;
            res_im <= rd_q.im;
            res_st <= ST_OK;
            state  <= S_DONE;
          end else if (n_r < CW'(2)) begin
            res_re <= '0;
            res_im <= '0;
            res_st <= ST_OUTSIDE;
            state  <= S_DONE;
          end else begin
            prev  <= rd_q.coord;
            i     <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (q == rd_q.coord) begin
            res_re <= rd_q.re;
            res_im <= rd_q.im;
            res_st <= ST_OK;
            state  <= S_DONE;
          end else if (prev < q && q < rd_q.coord) begin
            cl    <= i;
            state <= S_CLS;
          end else begin
            prev <= rd_q.coord;
            if (i + CW'(2) < n_r) begin
              i <= i + CW'(1);
            end else begin
              res_re <= '0;
              res_im <= '0;
              res_st <= ST_OUTSIDE;
              state  <= S_DONE;
            end
          end
        end
        S_CLS: begin
          if (cls_few) begin
            res_re <= '0;
            res_im <= '0;
            res_st <= ST_FEW;
            state  <= S_DONE;
          end else begin
            start_r <= cls_start;
            stop_r  <= cls_stop;
            li      <= cls_start;
            acc_re  <= '0;
            acc_im  <= '0;
            state   <= S_LI;
          end
        end
        S_LI: state <= S_LI2;
        S_LI2: begin
          gi    <= rd_q.coord;
          si_re <= rd_q.re;
          si_im <= rd_q.im;
          w     <= ONE_Q16;
          j     <= start_r;
          state <= S_LJ;
        end
        S_LJ: begin
          if (j == stop_r) state <= S_TRE;
          else if (j == li) j <= j + CW'(1);
          else state <= S_LD;
        end
        S_LD: begin
          neg_r <= num[32] ^ den[32];
          if (den == '0) begin
            ratio <= '0;
            state <= S_MUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ratio <= ratio_sat;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_WUPD;
        S_WUPD: begin
          w     <= sat32(term);
          j     <= j + CW'(1);
          state <= S_LJ;
        end
        S_TRE: state <= S_TIM;
        S_TIM: begin
          acc_re <= acc_re + term_ext;
          state  <= S_TACC;
        end
        S_TACC: begin
          acc_im <= acc_im + term_ext;
          li     <= li + CW'(1);
          state  <= (li + CW'(1) == stop_r) ? S_FIN : S_LI;
        end
        S_FIN: begin
          res_re <= sat_acc(acc_re);
          res_im <= sat_acc(acc_im);
          res_st <= ST_OK;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            result_re <= res_re;
            result_im <= res_im;
            status    <= res_st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DIV))
    else $error("divider running outside the divide step");

  a_j_in_stencil: assert property (@(posedge clk) disable iff (rst)
    (state == S_LD) |-> (j < stop_r && j != li))
    else $error("stencil read out of range");

  a_stencil_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_LI) |-> (stop_r <= n_r && li < stop_r))
    else $error("stencil beyond points in use");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE))
    else $error("command taken while busy");

endmodule

FILE: sv/lagrange_grid_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_grid_interpolator
// Complex Lagrange interpolation over a loaded Q16.16 grid.
// ----------------------------------------------------------------------------
// Loads: written to the grid store after two input/queue register stages.
// Query: interval search over the grid store, then per stencil point one
//   division by the 48-step shared divider for each other point (skipped when
//   the abscissae are equal); one query at a time.
// Reset clears control and configuration (linear order, two points); the grid
//   store holds no reset value and must be loaded before use.
module lagrange_grid_interpolator import lgi_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [5:0]         point_index,
  input  logic signed [31:0] abscissa,
  input  logic signed [31:0] sample_re,
  input  logic signed [31:0] sample_im,
  input  logic signed [31:0] query_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_re,
  output logic signed [31:0] result_im,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);

  logic [2:0] interp_order;
  logic [6:0] point_count;
  logic       push, push_ready, pop_valid, pop;
  cmd_t       push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_order <= ORD_LINEAR;
      point_count  <= 7'd2;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ORDER) interp_order <= cfg_data[2:0];
      else point_count <= cfg_data;
    end
  end

  lgi_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .point_index (point_index),
    .abscissa    (abscissa),
    .sample_re   (sample_re),
    .sample_im   (sample_im),
    .query_point (query_point),
    .push        (push),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  lgi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  lgi_engine #(.MAX_POINTS(MAX_POINTS)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (pop_valid),
    .cmd          (pop_cmd),
    .cmd_pop      (pop),
    .interp_order (interp_order),
    .point_count  (point_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_re    (result_re),
    .result_im    (result_im),
    .status       (status)
  );

endmodule
